/* hw/rtl/text_console_char_engine_defines.svh */
// Assertion shorthands for the checker of this block.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH

// same-cycle implication
`define TCCE_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCCE_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tcce_pkg.sv */
`default_nettype none

package tcce_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam int REQ_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int IDX_W   = 11;
	localparam int CELL_W  = 16;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

	localparam logic [CELL_W-1:0] CELL_RESET = 16'h0F20;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	// register index, taken from paddr above the byte offset
	localparam logic [PADDR_W-3:0] REG_ATTR = '0;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUT   = 2'd0,
		REQ_SET   = 2'd1,
		REQ_READ  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		OP_PRINT,
		OP_NEWLINE,
		OP_RETURN,
		OP_BACKSPACE,
		OP_SET,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [IDX_W-1:0]  idx;
		logic              idx_ok;
	} cmd_t;

	typedef enum logic [2:0] {
		BE_INIT,
		BE_IDLE,
		BE_SCROLL,
		BE_FILL,
		BE_RESP
	} be_state_t;

	function automatic logic [IDX_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		lin_pos = IDX_W'(32'(row) * COLUMNS + 32'(col));
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/tcce_if.sv */
`default_nettype none

interface tcce_in_if;
	logic                       valid;
	logic                       ready;
	logic [tcce_pkg::REQ_W-1:0] req_type;
	logic [tcce_pkg::CHAR_W-1:0] char_code;
	logic [tcce_pkg::COL_W-1:0] cursor_col;
	logic [tcce_pkg::ROW_W-1:0] cursor_row;
	logic [tcce_pkg::IDX_W-1:0] cell_index;

	modport source (output valid, req_type, char_code, cursor_col, cursor_row, cell_index,
		input ready);
	modport sink (input valid, req_type, char_code, cursor_col, cursor_row, cell_index,
		output ready);
endinterface

interface tcce_out_if;
	logic                        valid;
	logic                        ready;
	logic [tcce_pkg::IDX_W-1:0]  cursor_pos;
	logic [tcce_pkg::CELL_W-1:0] cell_data;
	logic                        scrolled;

	modport source (output valid, cursor_pos, cell_data, scrolled, input ready);
	modport sink (input valid, cursor_pos, cell_data, scrolled, output ready);
endinterface

`default_nettype wire

/* hw/rtl/text_console_char_engine.sv */
// A word taken on req passes the command queue, then execute and result; then rsp.valid rises.
// Print, control, set-cursor and read requests go one at a time: a new word leaves the queue
// only after the result of the last one has been loaded into the result register.
// A scroll or a clear adds one pass over the store, one cell a cycle.
// Reset (arst_n low, asynchronous) clears cursor, queue and attribute (0x0F); afterwards
// a pass over the store fills it with 0x0F20 while req.ready stays low.
`default_nettype none

module text_console_char_engine (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	tcce_in_if.sink                             req,
	tcce_out_if.source                          rsp,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tcce_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [tcce_pkg::PDATA_W-1:0]   pwdata,
	output logic      [tcce_pkg::PDATA_W-1:0]   prdata,
	output logic                                pready
);
	import tcce_pkg::*;

	logic [ATTR_W-1:0] attr_q;
	cmd_t              fe_cmd;
	logic              fe_valid;
	logic              fe_ready;
	cmd_t              be_cmd;
	logic              be_valid;
	logic              be_ready;
	logic              init_busy;
	logic              reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_ATTR;

	always_comb begin
		prdata = '0;
		if (reg_hit) prdata = PDATA_W'(attr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	tcce_front u_front (
		.req       (req),
		.init_busy (init_busy),
		.cmd       (fe_cmd),
		.cmd_valid (fe_valid),
		.cmd_ready (fe_ready)
	);

	tcce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (fe_cmd),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.pop_cmd    (be_cmd),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready)
	);

	tcce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.attr      (attr_q),
		.cmd       (be_cmd),
		.cmd_valid (be_valid),
		.cmd_ready (be_ready),
		.init_busy (init_busy),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

/* hw/rtl/tcce_front.sv */
`default_nettype none

module tcce_front (
	tcce_in_if.sink         req,
	input  wire logic       init_busy,
	output tcce_pkg::cmd_t  cmd,
	output logic            cmd_valid,
	input  wire logic       cmd_ready
);
	import tcce_pkg::*;

	assign req.ready = cmd_ready && !init_busy;
	assign cmd_valid = req.valid && !init_busy;

	always_comb begin
		cmd.ch  = req.char_code;
		cmd.idx = req.cell_index;
		cmd.idx_ok = 32'(req.cell_index) < CELL_COUNT;
		// set-cursor values saturate at the screen edge
		cmd.col = (32'(req.cursor_col) < COLUMNS) ? req.cursor_col : COL_W'(COLUMNS - 1);
		cmd.row = (32'(req.cursor_row) < ROWS) ? req.cursor_row : ROW_W'(ROWS - 1);
		unique case (req_type_t'(req.req_type))
			REQ_PUT: begin
				unique case (req.char_code)
					CH_NEWLINE:   cmd.op = OP_NEWLINE;
					CH_RETURN:    cmd.op = OP_RETURN;
					CH_BACKSPACE: cmd.op = OP_BACKSPACE;
					default:      cmd.op = OP_PRINT;
				endcase
			end
			REQ_SET:   cmd.op = OP_SET;
			REQ_READ:  cmd.op = OP_READ;
			REQ_CLEAR: cmd.op = OP_CLEAR;
			default:   cmd.op = OP_CLEAR;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/tcce_queue.sv */
`default_nettype none

module tcce_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tcce_pkg::cmd_t  push_cmd,
	input  wire logic            push_valid,
	output logic                 push_ready,
	output tcce_pkg::cmd_t       pop_cmd,
	output logic                 pop_valid,
	input  wire logic            pop_ready
);
	import tcce_pkg::*;

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != QCNT_W'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = ent_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tcce_back.sv */
`default_nettype none

module tcce_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [tcce_pkg::ATTR_W-1:0]  attr,
	input  wire tcce_pkg::cmd_t               cmd,
	input  wire logic                         cmd_valid,
	output logic                              cmd_ready,
	output logic                              init_busy,
	tcce_out_if.source                        rsp
);
	import tcce_pkg::*;

	logic [CELL_W-1:0] mem [CELL_COUNT];

	be_state_t         state_q, state_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic              res_read_q, res_read_d;
	logic              res_scr_q, res_scr_d;
	logic [CELL_W-1:0] rdata_q;
	logic              pend_q;
	logic              pend_blank_q;
	logic [IDX_W-1:0]  pend_addr_q;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_pos_q;
	logic [CELL_W-1:0] out_cell_q;
	logic              out_scr_q;

	logic              re;
	logic [IDX_W-1:0]  raddr;
	logic              we_x;
	logic [IDX_W-1:0]  xaddr;
	logic [CELL_W-1:0] xdata;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [CELL_W-1:0] wdata;
	logic              issue;
	logic              load_out;
	logic [CELL_W-1:0] blank;
	logic [IDX_W-1:0]  pos_cur;

	assign blank   = {attr, CH_SPACE};
	assign pos_cur = lin_pos(row_q, col_q);

	assign init_busy     = state_q == BE_INIT;
	assign rsp.valid     = out_valid_q;
	assign rsp.cursor_pos = out_pos_q;
	assign rsp.cell_data = out_cell_q;
	assign rsp.scrolled  = out_scr_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		row_d      = row_q;
		col_d      = col_q;
		res_read_d = res_read_q;
		res_scr_d  = res_scr_q;
		re         = 1'b0;
		raddr      = '0;
		we_x       = 1'b0;
		xaddr      = pos_cur;
		xdata      = blank;
		issue      = 1'b0;
		cmd_ready  = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			BE_INIT: begin
				we_x  = 1'b1;
				xaddr = cnt_q;
				xdata = CELL_RESET;
				if (32'(cnt_q) == CELL_COUNT - 1) begin
					cnt_d   = '0;
					state_d = BE_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			BE_IDLE: begin
				if (cmd_valid) begin
					cmd_ready  = 1'b1;
					res_read_d = 1'b0;
					res_scr_d  = 1'b0;
					state_d    = BE_RESP;
					unique case (cmd.op) inside
						OP_PRINT, OP_NEWLINE: begin
							if (cmd.op == OP_PRINT) begin
								we_x  = 1'b1;
								xdata = {attr, cmd.ch};
							end
							if (cmd.op == OP_NEWLINE || 32'(col_q) == COLUMNS - 1) begin
								col_d = '0;
								if (32'(row_q) == ROWS - 1) begin
									// row stays on the last line, screen moves up
									res_scr_d = 1'b1;
									cnt_d     = '0;
									state_d   = BE_SCROLL;
								end else begin
									row_d = row_q + 1'b1;
								end
							end else begin
								col_d = col_q + 1'b1;
							end
						end
						OP_RETURN: col_d = '0;
						OP_BACKSPACE: begin
							// previous cell is pos_cur-1 in both the same-row and wrap cases
							xaddr = pos_cur - 1'b1;
							if (col_q != '0) begin
								we_x  = 1'b1;
								col_d = col_q - 1'b1;
							end else if (row_q != '0) begin
								we_x  = 1'b1;
								row_d = row_q - 1'b1;
								col_d = COL_W'(COLUMNS - 1);
							end
						end
						OP_SET: begin
							col_d = cmd.col;
							row_d = cmd.row;
						end
						OP_READ: begin
							re         = 1'b1;
							raddr      = cmd.idx_ok ? cmd.idx : '0;
							res_read_d = cmd.idx_ok;
						end
						OP_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							cnt_d   = '0;
							state_d = BE_FILL;
						end
						default: ;
					endcase
				end
			end
			BE_SCROLL: begin
				// read one row ahead, write back in the next cycle; bottom row gets blanks
				re    = 1'b1;
				issue = 1'b1;
				raddr = (32'(cnt_q) < CELL_COUNT - COLUMNS) ?
					IDX_W'(32'(cnt_q) + COLUMNS) : cnt_q;
				if (32'(cnt_q) == CELL_COUNT - 1) begin
					cnt_d   = '0;
					state_d = BE_RESP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			BE_FILL: begin
				we_x  = 1'b1;
				xaddr = cnt_q;
				if (32'(cnt_q) == CELL_COUNT - 1) begin
					cnt_d   = '0;
					state_d = BE_RESP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			BE_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = BE_IDLE;
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	// the pending scroll write never meets another write: we_x is off in SCROLL and RESP
	always_comb begin
		we    = pend_q || we_x;
		waddr = pend_q ? pend_addr_q : xaddr;
		wdata = pend_q ? (pend_blank_q ? blank : rdata_q) : xdata;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		pend_addr_q  <= cnt_q;
		pend_blank_q <= 32'(cnt_q) >= CELL_COUNT - COLUMNS;
		if (load_out) begin
			out_pos_q  <= pos_cur;
			out_cell_q <= res_read_q ? rdata_q : '0;
			out_scr_q  <= res_scr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BE_INIT;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			res_read_q  <= 1'b0;
			res_scr_q   <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			row_q      <= row_d;
			col_q      <= col_d;
			res_read_q <= res_read_d;
			res_scr_q  <= res_scr_d;
			pend_q     <= issue;
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tcce_chk.sv */
`default_nettype none

`include "text_console_char_engine_defines.svh"

module tcce_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [tcce_pkg::IDX_W-1:0]    cursor_pos,
	input wire logic [tcce_pkg::CELL_W-1:0]   cell_data,
	input wire logic                          scrolled
);
	import tcce_pkg::*;

	`TCCE_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`TCCE_NEXT(a_out_stable, out_valid && !out_ready, $stable(cursor_pos) && $stable(cell_data) && $stable(scrolled), "result word changed while stalled")
	`TCCE_CHECK(a_pos_range, out_valid, 32'(cursor_pos) < CELL_COUNT, "cursor outside the screen")
	`TCCE_CHECK(a_scroll_pos, out_valid && scrolled, 32'(cursor_pos) == CELL_COUNT - COLUMNS, "scroll left cursor off the start of the last row")

endmodule

bind text_console_char_engine tcce_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.cursor_pos (rsp.cursor_pos),
	.cell_data  (rsp.cell_data),
	.scrolled   (rsp.scrolled)
);

`default_nettype wire

/* test/text_console_char_engine_test.sv */
module text_console_char_engine_test;
	import tcce_pkg::*;

	localparam int TIMEOUT_CYCLES = 10_000_000;
	localparam int PHASE_ITEMS    = 255;
	localparam int IDX_MAX        = (1 << IDX_W) - 1;
	localparam logic [PADDR_W-1:0] ADDR_ATTR   = {REG_ATTR, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_NO_REG = PADDR_W'(4);

	typedef struct packed {
		req_type_t         kind;
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [IDX_W-1:0]  idx;
	} console_req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  pos;
		logic [CELL_W-1:0] cell_word;
		logic              scrolled;
	} console_rsp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	tcce_in_if  req();
	tcce_out_if rsp();

	text_console_char_engine uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// console state as the block should hold it
	logic [CELL_W-1:0] screen_model [CELL_COUNT];
	int unsigned       row_now;
	int unsigned       col_now;
	logic [ATTR_W-1:0] attr_now;

	console_req_t pending_reqs[$];
	console_rsp_t predicted_rsps[$];
	int unsigned  queued;
	int unsigned  fails;
	int unsigned  cycles;
	logic         word_taken = 1'b0;
	int unsigned  burst_left;
	int unsigned  gap_left;
	int unsigned  stall_mode;
	int unsigned  stall_span;

	function automatic logic [CELL_W-1:0] space_cell();
		return {attr_now, CH_SPACE};
	endfunction

	task automatic line_feed(output logic rolled);
		rolled = 1'b0;
		col_now = 0;
		row_now++;
		if (row_now >= ROWS) begin
			for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
				screen_model[i] = screen_model[i + COLUMNS];
			for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
				screen_model[i] = space_cell();
			row_now = ROWS - 1;
			rolled = 1'b1;
		end
	endtask

	task automatic console_update(input console_req_t r, output console_rsp_t o);
		logic [CELL_W-1:0] rd_word;
		logic              rolled;
		rd_word = '0;
		rolled = 1'b0;
		case (r.kind)
			REQ_PUT: begin
				if (r.ch == CH_NEWLINE) begin
					line_feed(rolled);
				end else if (r.ch == CH_RETURN) begin
					col_now = 0;
				end else if (r.ch == CH_BACKSPACE) begin
					if (col_now > 0) begin
						col_now--;
						screen_model[row_now * COLUMNS + col_now] = space_cell();
					end else if (row_now > 0) begin
						// back up to the end of the previous row
						row_now--;
						col_now = COLUMNS - 1;
						screen_model[row_now * COLUMNS + col_now] = space_cell();
					end
				end else begin
					screen_model[row_now * COLUMNS + col_now] = {attr_now, r.ch};
					col_now++;
					if (col_now >= COLUMNS)
						line_feed(rolled);
				end
			end
			REQ_SET: begin
				col_now = (r.col < COLUMNS) ? r.col : COLUMNS - 1;
				row_now = (r.row < ROWS) ? r.row : ROWS - 1;
			end
			REQ_READ: begin
				if (r.idx < CELL_COUNT)
					rd_word = screen_model[r.idx];
			end
			default: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen_model[i] = space_cell();
				row_now = 0;
				col_now = 0;
			end
		endcase
		o.pos = IDX_W'(row_now * COLUMNS + col_now);
		o.cell_word = rd_word;
		o.scrolled = rolled;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			fails++;
			$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endfunction

	function automatic console_req_t rnd_req(input req_type_t k);
		console_req_t r;
		r.kind = k;
		r.ch = CHAR_W'($urandom);
		r.col = COL_W'($urandom);
		r.row = ROW_W'($urandom);
		r.idx = IDX_W'($urandom);
		return r;
	endfunction

	task automatic push_req(input console_req_t r);
		pending_reqs.push_back(r);
		queued++;
	endtask

	// fields the request does not use keep random content
	task automatic add_req(input req_type_t k, input int unsigned a = 0, input int unsigned b = 0);
		console_req_t r;
		r = rnd_req(k);
		case (k)
			REQ_PUT: r.ch = CHAR_W'(a);
			REQ_SET: begin
				r.col = COL_W'(a);
				r.row = ROW_W'(b);
			end
			REQ_READ: r.idx = IDX_W'(a);
			default: ;
		endcase
		push_req(r);
	endtask

	function automatic int unsigned text_char();
		int unsigned p, c;
		p = $urandom_range(0, 99);
		if (p < 4)
			return CH_NEWLINE;
		if (p < 8)
			return CH_RETURN;
		if (p < 14)
			return CH_BACKSPACE;
		c = $urandom_range(0, 255);
		if (c == CH_NEWLINE || c == CH_RETURN || c == CH_BACKSPACE)
			c = c + 8'h40;
		return c;
	endfunction

	task automatic add_sequence();
		int unsigned pick, row, col, n, base;
		req_type_t   k;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			col = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, COLUMNS - 1);
			row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, ROWS - 1);
			add_req(REQ_SET, col, row);
			n = $urandom_range(1, 20);
			repeat (n) add_req(REQ_PUT, text_char());
			base = (row < ROWS ? row : ROWS - 1) * COLUMNS + (col < COLUMNS ? col : COLUMNS - 1);
			repeat ($urandom_range(1, 4)) add_req(REQ_READ, base + $urandom_range(0, n));
		end else if (pick < 57) begin
			// run off the bottom row so the screen scrolls
			add_req(REQ_SET, $urandom_range(COLUMNS - 10, COLUMNS - 1), ROWS - 1);
			repeat ($urandom_range(4, 16)) begin
				if ($urandom_range(0, 7) == 0)
					add_req(REQ_PUT, CH_NEWLINE);
				else
					add_req(REQ_PUT, $urandom_range(8'h20, 8'h7E));
			end
			repeat ($urandom_range(1, 4))
				add_req(REQ_READ, $urandom_range((ROWS - 2) * COLUMNS, CELL_COUNT - 1));
		end else if (pick < 67) begin
			row = $urandom_range(0, ROWS - 1);
			add_req(REQ_SET, $urandom_range(0, 2), row);
			repeat ($urandom_range(1, 5)) add_req(REQ_PUT, CH_BACKSPACE);
			add_req(REQ_PUT, text_char());
			if (row > 0)
				add_req(REQ_READ, row * COLUMNS - 1);
			add_req(REQ_READ, row * COLUMNS + $urandom_range(0, 2));
		end else if (pick < 82) begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 9) == 0)
					add_req(REQ_READ, $urandom_range(CELL_COUNT, IDX_MAX));
				else
					add_req(REQ_READ, $urandom_range(0, CELL_COUNT - 1));
			end
		end else if (pick < 84) begin
			add_req(REQ_CLEAR);
		end else begin
			repeat ($urandom_range(1, 5)) begin
				k = req_type_t'($urandom_range(0, 3));
				if (k == REQ_CLEAR && $urandom_range(0, 3) != 0)
					k = REQ_READ;
				push_req(rnd_req(k));
			end
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || req.valid || predicted_rsps.size() != 0);
	endtask

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (addr == ADDR_ATTR)
			attr_now = data[ATTR_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// sender: bursts of words with random gaps in between
	always @(negedge clk) begin : driver
		console_req_t nxt;
		if (arst_n && (word_taken || !req.valid)) begin
			if (gap_left > 0) begin
				gap_left--;
				req.valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				nxt = pending_reqs.pop_front();
				req.valid <= 1'b1;
				req.req_type <= nxt.kind;
				req.char_code <= nxt.ch;
				req.cursor_col <= nxt.col;
				req.cursor_row <= nxt.row;
				req.cell_index <= nxt.idx;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches among four modes, chosen at random
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(50, 300);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 2) != 0);
			2: rsp.ready <= (stall_span % 5) < 2;
			default: rsp.ready <= (stall_span % 16) >= 8;
		endcase
	end

	always @(posedge clk) begin : monitor
		console_req_t seen;
		console_rsp_t got;
		console_rsp_t want;
		word_taken <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready) begin
			seen.kind = req_type_t'(req.req_type);
			seen.ch = req.char_code;
			seen.col = req.cursor_col;
			seen.row = req.cursor_row;
			seen.idx = req.cell_index;
			console_update(seen, want);
			predicted_rsps.push_back(want);
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			got.pos = rsp.cursor_pos;
			got.cell_word = rsp.cell_data;
			got.scrolled = rsp.scrolled;
			if (predicted_rsps.size() == 0) begin
				fails++;
				$error("result word with no request waiting: cursor_pos %0h", got.pos);
			end else begin
				want = predicted_rsps.pop_front();
				check_field("cursor_pos", want.pos, got.pos);
				check_field("cell_data", want.cell_word, got.cell_word);
				check_field("scrolled", want.scrolled, got.scrolled);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : main
		int unsigned target;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req.valid = 1'b0;
		req.req_type = '0;
		req.char_code = '0;
		req.cursor_col = '0;
		req.cursor_row = '0;
		req.cell_index = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < CELL_COUNT; i++)
			screen_model[i] = CELL_RESET;
		row_now = 0;
		col_now = 0;
		attr_now = ATTR_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset contents and out-of-range reads
		add_req(REQ_READ, 0);
		add_req(REQ_READ, CELL_COUNT - 1);
		add_req(REQ_READ, CELL_COUNT);
		add_req(REQ_READ, IDX_MAX);
		// printable bytes including zero and all-ones, then erase one
		add_req(REQ_PUT, 8'h41);
		add_req(REQ_PUT, 8'h00);
		add_req(REQ_PUT, 8'hFF);
		add_req(REQ_PUT, CH_BACKSPACE);
		add_req(REQ_READ, 1);
		// backspace at the home position does nothing
		add_req(REQ_SET, 0, 0);
		add_req(REQ_PUT, CH_BACKSPACE);
		// saturating set, then print in the last cell: wrap and scroll
		add_req(REQ_SET, 127, 31);
		add_req(REQ_PUT, 8'h7E);
		add_req(REQ_READ, CELL_COUNT - COLUMNS - 1);
		// backspace at column zero goes to the end of the row above
		add_req(REQ_SET, 0, 5);
		add_req(REQ_PUT, CH_BACKSPACE);
		add_req(REQ_PUT, CH_RETURN);
		// newline on the last row scrolls
		add_req(REQ_SET, 10, ROWS - 1);
		add_req(REQ_PUT, CH_NEWLINE);
		add_req(REQ_SET, 3, 31);
		add_req(REQ_CLEAR);
		add_req(REQ_READ, CELL_COUNT - 1);
		// wrap off the end of a row without scrolling
		add_req(REQ_SET, COLUMNS - 1, 0);
		add_req(REQ_PUT, 8'h5A);
		add_req(REQ_PUT, CH_NEWLINE);
		add_req(REQ_READ, COLUMNS - 1);
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 2)
				reg_write(ADDR_NO_REG, $urandom);
			case (phase)
				0: reg_write(ADDR_ATTR, 32'h0000_0000);
				1: reg_write(ADDR_ATTR, 32'hFFFF_FFFF);
				3: reg_write(ADDR_ATTR, 32'h0000_000F);
				default: reg_write(ADDR_ATTR, $urandom);
			endcase
			@(posedge clk);
			target = queued + PHASE_ITEMS;
			while (queued < target)
				add_sequence();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fails == 0 && predicted_rsps.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
